// ===== src/assert_macros.svh =====
// Assertion helpers used by the bound checker brds_checker of this project.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define BRDS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define BRDS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/brds_pkg.sv =====
`timescale 1ns / 1ps
package brds_pkg;

  localparam int unsigned SAMPLE_W   = 24;
  localparam int unsigned MAX_CELLS  = 4096;
  localparam int unsigned HALO       = 4;
  localparam int unsigned WIN        = 2 * HALO + 1;
  localparam int unsigned POS_CAP    = MAX_CELLS + 2 * HALO;
  localparam int unsigned POS_W      = $clog2(POS_CAP + 1);
  localparam int unsigned LEN_W      = 13;
  localparam int unsigned IDX_W      = 12;
  localparam int unsigned RES_W      = 32;

  // Numerators are scaled to the common denominator 840. The one-sided edge
  // stencils then reach 3360 * 2^(SAMPLE_W-1) in magnitude, which needs
  // twelve bits above the sample width including the sign.
  localparam int unsigned NUM_W      = SAMPLE_W + 12;
  localparam int unsigned MAG_W      = NUM_W - 1;
  localparam int unsigned PROD_W     = MAG_W + LEN_W;
  localparam int unsigned DIGITS     = (PROD_W + 1 + 3) / 4;
  localparam int unsigned DIVIDEND_W = 4 * DIGITS;
  localparam int unsigned STEP_W     = $clog2(DIGITS);
  localparam int unsigned DIVISOR    = 1680;
  localparam int unsigned ROUND_BIAS = 840;
  localparam int unsigned REM_W      = 11;
  localparam int unsigned QUO_W      = RES_W + 1;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);

  localparam int unsigned CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_ORDER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY    = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(64);
  localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(3);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_CELLS);

  localparam logic [RES_W-1:0] RES_POS_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] RES_NEG_MAX = {1'b1, {(RES_W-1){1'b0}}};

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [IDX_W-1:0]        cell_index;
    logic                    last_cell;
  } brds_item_t;

endpackage

// ===== src/boundary_reduced_difference_stencil_top.sv =====
// First-derivative stencil along one streamed grid line.
// Input channel (in_valid_i/in_ready_o): one sample per transaction, four leading
// halo samples, the interior cells, then four trailing halo samples; line_end_i
// marks the last trailing halo sample and restarts the line count.
// Output channel (out_valid_o/out_ready_i): one transaction per interior cell,
// carrying the saturated Q12.20 derivative, the cell index, a last-cell flag
// and a saturation flag.
// Configuration channel (cfg_valid_i/cfg_ready_o): always ready; index 0 is the
// line length (clamped to 3..4096), 1 selects eighth order, 2 selects the
// reduced-order boundary scheme. Write it only while the block is idle.
// Samples that complete no cell are taken one per cycle while no earlier cell
// waits for queue space. Each cell occupies the arithmetic back end for a load,
// a multiply and the 13 digit steps of the radix-16 long division by twice the
// common denominator, and the back end takes a new cell only once it is idle.
// A two-entry queue between the front and the back end lets samples keep
// flowing while a result is worked out or waits in the output register.
// If the receiver stalls, the output register holds its transaction, the back
// end waits, the queue fills and in_ready_o falls. Reset empties every stage
// and restores the register defaults (length 64, sixth order, uniform mode).
`timescale 1ns / 1ps
module boundary_reduced_difference_stencil_top
  import brds_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [LEN_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       line_end_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [RES_W-1:0]    derivative_o,
  output logic [IDX_W-1:0]           cell_index_o,
  output logic                       last_cell_o,
  output logic                       saturated_o
);

  logic [LEN_W-1:0] line_len_q;
  logic             high_order_q, boundary_q;
  logic             push, full, pop, fifo_valid;
  brds_item_t       front_item, fifo_item;

  // The configuration port never stalls.
  assign cfg_ready_o = 1'b1;

  // The line length is stored already clamped, since it serves both as the
  // cell count and as the 1/h multiplier.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_len_q   <= LEN_RESET;
      high_order_q <= 1'b0;
      boundary_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LINE_LENGTH: begin
          if (cfg_data_i < LEN_MIN) begin
            line_len_q <= LEN_MIN;
          end else if (cfg_data_i > LEN_MAX) begin
            line_len_q <= LEN_MAX;
          end else begin
            line_len_q <= cfg_data_i;
          end
        end
        CFG_HIGH_ORDER: high_order_q <= cfg_data_i[0];
        CFG_BOUNDARY:   boundary_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Front end: sample window, line position and stencil selection.
  brds_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .sample_i        (sample_i),
    .line_end_i      (line_end_i),
    .line_len_i      (line_len_q),
    .high_order_i    (high_order_q),
    .boundary_mode_i (boundary_q),
    .push_o          (push),
    .item_o          (front_item),
    .full_i          (full)
  );

  // Short queue of scaled numerators awaiting the back end.
  brds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (fifo_item),
    .valid_o (fifo_valid)
  );

  // Back end: scaling by the line length, rounding division and saturation.
  brds_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (fifo_valid),
    .item_i       (fifo_item),
    .pop_o        (pop),
    .line_len_i   (line_len_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .derivative_o (derivative_o),
    .cell_index_o (cell_index_o),
    .last_cell_o  (last_cell_o),
    .saturated_o  (saturated_o)
  );

endmodule

// ===== src/brds_front.sv =====
`timescale 1ns / 1ps
module brds_front
  import brds_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       line_end_i,
  input  logic [LEN_W-1:0]           line_len_i,
  input  logic                       high_order_i,
  input  logic                       boundary_mode_i,
  output logic                       push_o,
  output brds_item_t                 item_o,
  input  logic                       full_i
);

  typedef enum logic [2:0] {
    ST_CD2, ST_CD4, ST_CD6, ST_CD8, ST_LEFT, ST_RIGHT
  } stencil_e;

  localparam logic signed [NUM_W-1:0] K3    = NUM_W'(3);
  localparam logic signed [NUM_W-1:0] K14   = NUM_W'(14);
  localparam logic signed [NUM_W-1:0] K32   = NUM_W'(32);
  localparam logic signed [NUM_W-1:0] K70   = NUM_W'(70);
  localparam logic signed [NUM_W-1:0] K126  = NUM_W'(126);
  localparam logic signed [NUM_W-1:0] K168  = NUM_W'(168);
  localparam logic signed [NUM_W-1:0] K420  = NUM_W'(420);
  localparam logic signed [NUM_W-1:0] K560  = NUM_W'(560);
  localparam logic signed [NUM_W-1:0] K630  = NUM_W'(630);
  localparam logic signed [NUM_W-1:0] K672  = NUM_W'(672);
  localparam logic signed [NUM_W-1:0] K1260 = NUM_W'(1260);
  localparam logic signed [NUM_W-1:0] K1680 = NUM_W'(1680);

  logic signed [SAMPLE_W-1:0] window_q [WIN];
  logic signed [NUM_W-1:0]    f [WIN];
  logic signed [NUM_W-1:0]    d1, d2, d3, d4, num;
  logic [POS_W-1:0]           pos_q, pos_d, cell_pos;
  logic [LEN_W-1:0]           cell_len, rev, cell_q;
  logic                       pend_q, last_q, accept, emit;
  stencil_e                   cls_q, cls_d;

  assign in_ready_o = !pend_q || !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign push_o     = pend_q && !full_i;

  // The sample at position p completes the cell p - 2*HALO.
  assign cell_pos = pos_q - POS_W'(2 * HALO);
  assign emit     = (pos_q >= POS_W'(2 * HALO)) && (32'(cell_pos) < 32'(line_len_i));
  assign cell_len = LEN_W'(cell_pos);
  assign rev      = line_len_i - cell_len - LEN_W'(1);

  always_comb begin
    pos_d = pos_q;
    if (line_end_i) begin
      pos_d = '0;
    end else if (pos_q < POS_W'(POS_CAP)) begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  // Stencil choice: the configured order, or in boundary mode by the distance to the nearer line end.
  always_comb begin
    cls_d = high_order_i ? ST_CD8 : ST_CD6;
    if (boundary_mode_i) begin
      if (cell_len == LEN_W'(0)) begin
        cls_d = ST_LEFT;
      end else if (rev == LEN_W'(0)) begin
        cls_d = ST_RIGHT;
      end else if (cell_len == LEN_W'(1) || rev == LEN_W'(1)) begin
        cls_d = ST_CD2;
      end else if (cell_len == LEN_W'(2) || rev == LEN_W'(2)) begin
        cls_d = ST_CD4;
      end else if (cell_len == LEN_W'(3) || rev == LEN_W'(3)) begin
        cls_d = ST_CD6;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < WIN - 1; k++) begin
        window_q[k] <= window_q[k+1];
      end
      window_q[WIN-1] <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      pend_q <= 1'b0;
      cls_q  <= ST_CD6;
      cell_q <= '0;
      last_q <= 1'b0;
    end else if (accept) begin
      pos_q  <= pos_d;
      pend_q <= emit;
      cls_q  <= cls_d;
      cell_q <= cell_len;
      last_q <= (rev == LEN_W'(0));
    end else if (push_o) begin
      pend_q <= 1'b0;
    end
  end

  // Numerator over the common denominator 840, from the settled window.
  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      f[k] = NUM_W'(window_q[k]);
    end
    d1 = f[HALO+1] - f[HALO-1];
    d2 = f[HALO+2] - f[HALO-2];
    d3 = f[HALO+3] - f[HALO-3];
    d4 = f[HALO+4] - f[HALO-4];
    unique case (cls_q)
      ST_CD2:   num = K420 * d1;
      ST_CD4:   num = K560 * d1 - K70 * d2;
      ST_CD6:   num = K630 * d1 - K126 * d2 + K14 * d3;
      ST_CD8:   num = K672 * d1 - K168 * d2 + K32 * d3 - K3 * d4;
      ST_LEFT:  num = K1680 * f[HALO+1] - K1260 * f[HALO] - K420 * f[HALO+2];
      ST_RIGHT: num = K1260 * f[HALO] - K1680 * f[HALO-1] + K420 * f[HALO-2];
      default:  num = '0;
    endcase
  end

  assign item_o.num        = num;
  assign item_o.cell_index = cell_q[IDX_W-1:0];
  assign item_o.last_cell  = last_q;

endmodule

// ===== src/brds_fifo.sv =====
`timescale 1ns / 1ps
module brds_fifo
  import brds_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  brds_item_t item_i,
  output logic       full_o,
  input  logic       pop_i,
  output brds_item_t item_o,
  output logic       valid_o
);

  brds_item_t             mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FIFO_PTR_W:0]    count_q;

  assign full_o  = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (FIFO_PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (FIFO_PTR_W+1)'(1);
      end
    end
  end

endmodule

// ===== src/brds_back.sv =====
`timescale 1ns / 1ps
module brds_back
  import brds_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  brds_item_t               item_i,
  output logic                     pop_o,
  input  logic [LEN_W-1:0]         line_len_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [RES_W-1:0]  derivative_o,
  output logic [IDX_W-1:0]         cell_index_o,
  output logic                     last_cell_o,
  output logic                     saturated_o
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_e;

  localparam int unsigned T_W = REM_W + 4;

  state_e                  state_q;
  logic [MAG_W-1:0]        mag_q, num_abs;
  logic                    neg_q, last_q, ovf_q, ovf_next, sat;
  logic [IDX_W-1:0]        cell_q;
  logic [DIVIDEND_W-1:0]   div_q, dividend;
  logic [PROD_W-1:0]       prod;
  logic [REM_W-1:0]        rem_q, rem_next;
  logic [QUO_W-1:0]        quo_q, quo_next;
  logic [STEP_W-1:0]       step_q;
  logic [T_W-1:0]          t;
  logic [3:0]              digit;
  logic [RES_W-1:0]        result;
  logic                    last_step, out_free, out_load;
  logic                    out_valid_q, last_out_q, sat_q;
  logic [RES_W-1:0]        deriv_q;
  logic [IDX_W-1:0]        idx_q;

  assign pop_o   = (state_q == S_IDLE) && valid_i;
  assign num_abs = item_i.num[NUM_W-1] ? MAG_W'(~item_i.num + NUM_W'(1)) : MAG_W'(item_i.num);

  // Twice the product plus half the divisor: the quotient by 1680 is then
  // the magnitude rounded half up.
  assign prod     = PROD_W'(mag_q) * PROD_W'(line_len_i);
  assign dividend = DIVIDEND_W'({prod, 1'b0}) + DIVIDEND_W'(ROUND_BIAS);

  // One radix-16 digit of the long division per cycle; the last one waits while the output register is full.
  always_comb begin
    t     = {rem_q, div_q[DIVIDEND_W-1 -: 4]};
    digit = 4'd0;
    for (int k = 1; k < 16; k++) begin
      if (32'(t) >= k * DIVISOR) begin
        digit = 4'(k);
      end
    end
  end

  assign rem_next  = REM_W'(32'(t) - 32'(digit) * DIVISOR);
  assign quo_next  = {quo_q[QUO_W-5:0], digit};
  assign ovf_next  = ovf_q || (quo_q[QUO_W-1 -: 4] != 4'd0);
  assign last_step = (step_q == STEP_W'(DIGITS - 1));
  assign out_free  = !out_valid_q || out_ready_i;
  assign out_load  = (state_q == S_DIV) && last_step && out_free;

  always_comb begin
    sat = ovf_next
       || (!neg_q && quo_next > QUO_W'(RES_POS_MAX))
       || (neg_q && quo_next > QUO_W'(RES_NEG_MAX));
    if (sat) begin
      result = neg_q ? RES_NEG_MAX : RES_POS_MAX;
    end else begin
      result = neg_q ? (~quo_next[RES_W-1:0] + RES_W'(1)) : quo_next[RES_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      cell_q      <= '0;
      last_q      <= 1'b0;
      div_q       <= '0;
      rem_q       <= '0;
      quo_q       <= '0;
      ovf_q       <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      deriv_q     <= '0;
      idx_q       <= '0;
      last_out_q  <= 1'b0;
      sat_q       <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (valid_i) begin
            mag_q   <= num_abs;
            neg_q   <= item_i.num[NUM_W-1];
            cell_q  <= item_i.cell_index;
            last_q  <= item_i.last_cell;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          div_q   <= dividend;
          rem_q   <= '0;
          quo_q   <= '0;
          ovf_q   <= 1'b0;
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (!last_step) begin
            div_q  <= div_q << 4;
            rem_q  <= rem_next;
            quo_q  <= quo_next;
            ovf_q  <= ovf_next;
            step_q <= step_q + STEP_W'(1);
          end else if (out_free) begin
            deriv_q     <= result;
            idx_q       <= cell_q;
            last_out_q  <= last_q;
            sat_q       <= sat;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign derivative_o = deriv_q;
  assign cell_index_o = idx_q;
  assign last_cell_o  = last_out_q;
  assign saturated_o  = sat_q;

endmodule

// ===== src/brds_checker.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module brds_checker
  import brds_pkg::*;
(
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic signed [RES_W-1:0]    derivative_i,
  input logic [IDX_W-1:0]           cell_index_i,
  input logic                       last_cell_i,
  input logic                       saturated_i
);

  `BRDS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `BRDS_ASSERT_NEXT(a_out_stable, out_valid_i && !out_ready_i, $stable(derivative_i) && $stable(cell_index_i))
  `BRDS_ASSERT_IMPL(a_sat_clip, out_valid_i && saturated_i, derivative_i == RES_POS_MAX || derivative_i == RES_NEG_MAX)
  `BRDS_ASSERT_IMPL(a_last_index, out_valid_i && last_cell_i, cell_index_i >= IDX_W'(2))

endmodule

bind boundary_reduced_difference_stencil_top brds_checker u_brds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .derivative_i (derivative_o),
  .cell_index_i (cell_index_o),
  .last_cell_i  (last_cell_o),
  .saturated_i  (saturated_o)
);

// ===== dv/stencil_result_checker.sv =====
`timescale 1ns / 1ps
module stencil_result_checker
  import brds_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [LEN_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  input  logic                       line_end_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic signed [RES_W-1:0]    derivative_i,
  input  logic [IDX_W-1:0]           cell_index_i,
  input  logic                       last_cell_i,
  input  logic                       saturated_i,
  output int                         fail_count_o,
  output int                         pending_o,
  output int                         checked_o,
  output int                         clipped_o
);

  typedef enum logic [2:0] {
    ORD_EDGE,
    ORD_CD2,
    ORD_CD4,
    ORD_CD6,
    ORD_CD8
  } stencil_order_e;

  typedef struct {
    logic signed [RES_W-1:0] derivative;
    logic [IDX_W-1:0]        cell_index;
    logic                    last_cell;
    logic                    saturated;
  } cell_result_t;

  localparam int unsigned EMIT_OFFSET = 2 * HALO;

  cell_result_t     pending_derivatives[$];
  cell_result_t     oldest;
  longint           taps[WIN];
  int unsigned      line_pos;
  int unsigned      prev_pos;
  int unsigned      eff_len;
  logic [LEN_W-1:0] line_length_q;
  logic             high_order_q;
  logic             reduced_edges_q;
  int               fail_count;
  int               pending_count;
  int               checked;
  int               clipped;

  assign fail_count_o = fail_count;
  assign pending_o    = pending_count;
  assign checked_o    = checked;
  assign clipped_o    = clipped;

  function automatic longint tap(input int m);
    return taps[HALO + m];
  endfunction

  function automatic longint cdiff(input int m);
    return tap(m) - tap(-m);
  endfunction

  // Rounds num * len / den to nearest, ties away from zero, and clips to the
  // signed result range. The top bit of the return value is the clip flag.
  function automatic logic [RES_W:0] scale_q20(input longint num,
                                               input longint unsigned len,
                                               input longint unsigned den);
    longint unsigned mag;
    longint unsigned quo;
    longint unsigned rem;
    longint unsigned res;
    logic            neg;
    logic            sat;
    neg = (num < 0);
    mag = neg ? -num : num;
    quo = mag / den;
    rem = mag % den;
    res = 0;
    sat = 1'b0;
    if (quo > (64'd1 << 32)) begin
      sat = 1'b1;
    end else begin
      res = quo * len + (2 * rem * len + den) / (2 * den);
      if (!neg && res > 64'h7FFF_FFFF) sat = 1'b1;
      if (neg && res > 64'h8000_0000) sat = 1'b1;
    end
    if (sat) return {1'b1, neg ? RES_NEG_MAX : RES_POS_MAX};
    return {1'b0, neg ? RES_W'(64'd0 - res) : RES_W'(res)};
  endfunction

  function automatic cell_result_t predict_derivative(input int unsigned cell_no,
                                                      input int unsigned len);
    stencil_order_e  order;
    int unsigned     end_gap;
    longint          num;
    longint unsigned den;
    logic [RES_W:0]  scaled;
    cell_result_t    res;
    order = high_order_q ? ORD_CD8 : ORD_CD6;
    if (reduced_edges_q) begin
      end_gap = (len - 1 - cell_no < cell_no) ? len - 1 - cell_no : cell_no;
      case (end_gap)
        0: order = ORD_EDGE;
        1: order = ORD_CD2;
        2: order = ORD_CD4;
        3: order = ORD_CD6;
        default: ;
      endcase
    end
    case (order)
      ORD_EDGE: begin
        den = 2;
        if (cell_no == 0) num = -3 * tap(0) + 4 * tap(1) - tap(2);
        else num = 3 * tap(0) - 4 * tap(-1) + tap(-2);
      end
      ORD_CD2: begin
        num = cdiff(1);
        den = 2;
      end
      ORD_CD4: begin
        num = 8 * cdiff(1) - cdiff(2);
        den = 12;
      end
      ORD_CD6: begin
        num = 45 * cdiff(1) - 9 * cdiff(2) + cdiff(3);
        den = 60;
      end
      default: begin
        num = 672 * cdiff(1) - 168 * cdiff(2) + 32 * cdiff(3) - 3 * cdiff(4);
        den = 840;
      end
    endcase
    scaled         = scale_q20(num, len, den);
    res.derivative = scaled[RES_W-1:0];
    res.saturated  = scaled[RES_W];
    res.cell_index = cell_no[IDX_W-1:0];
    res.last_cell  = (cell_no == len - 1);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WIN; k++) taps[k] = 0;
      pending_derivatives.delete();
      line_pos        = 0;
      line_length_q   = LEN_RESET;
      high_order_q    = 1'b0;
      reduced_edges_q = 1'b0;
      fail_count      = 0;
      pending_count   = 0;
      checked         = 0;
      clipped         = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LINE_LENGTH: line_length_q   = cfg_data_i;
          CFG_HIGH_ORDER:  high_order_q    = cfg_data_i[0];
          CFG_BOUNDARY:    reduced_edges_q = cfg_data_i[0];
          default: ;
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (pending_count == 0) begin
          $display("%0t: unexpected derivative %0d for cell %0d", $time, derivative_i,
                   cell_index_i);
          fail_count++;
        end else begin
          oldest = pending_derivatives.pop_front();
          pending_count--;
          checked++;
          if (oldest.saturated) clipped++;
          if (oldest.derivative !== derivative_i) begin
            $display("%0t: derivative of cell %0d expected %0d, got %0d", $time,
                     oldest.cell_index, oldest.derivative, derivative_i);
            fail_count++;
          end
          if (oldest.cell_index !== cell_index_i) begin
            $display("%0t: cell index expected %0d, got %0d", $time, oldest.cell_index,
                     cell_index_i);
            fail_count++;
          end
          if (oldest.last_cell !== last_cell_i) begin
            $display("%0t: last cell flag of cell %0d expected %0b, got %0b", $time,
                     oldest.cell_index, oldest.last_cell, last_cell_i);
            fail_count++;
          end
          if (oldest.saturated !== saturated_i) begin
            $display("%0t: clip flag of cell %0d expected %0b, got %0b", $time,
                     oldest.cell_index, oldest.saturated, saturated_i);
            fail_count++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        eff_len = (line_length_q < LEN_MIN) ? LEN_MIN :
                  (line_length_q > LEN_MAX) ? LEN_MAX : line_length_q;
        for (int k = 0; k < WIN - 1; k++) taps[k] = taps[k + 1];
        taps[WIN - 1] = longint'(sample_i);
        prev_pos = line_pos;
        if (line_end_i) line_pos = 0;
        else if (line_pos < POS_CAP) line_pos++;
        if (prev_pos >= EMIT_OFFSET && prev_pos - EMIT_OFFSET < eff_len) begin
          pending_derivatives.push_back(predict_derivative(prev_pos - EMIT_OFFSET, eff_len));
          pending_count++;
        end
      end
    end
  end

endmodule

// ===== dv/tb_boundary_reduced_difference_stencil_top.sv =====
`timescale 1ns / 1ps
module tb_boundary_reduced_difference_stencil_top;
  import brds_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  // Number of random stimulus transactions aimed at after the directed part.
  localparam int RANDOM_ITEMS  = 850;
  // Cycles allowed for the front end to empty after the last result.
  localparam int SETTLE_CYCLES = 32;
  // Length of the long receiver hold-off that fills the internal queue.
  localparam int LONG_HOLD     = 400;
  localparam int IDLE_PERCENT  = 33;
  localparam int WATCHDOG_NS   = 10_000_000;
  // The configuration index that maps to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [LEN_W-1:0]           cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       line_end;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [RES_W-1:0]    derivative;
  logic [IDX_W-1:0]           cell_index;
  logic                       last_cell;
  logic                       saturated;

  int fail_count;
  int pending;
  int checked;
  int clipped;

  // Stimulus controls for the sender tasks and the receiver process.
  bit tx_gaps;
  bit rx_gaps;
  int hold_left;

  int samples_sent;
  int lines_sent;
  int random_base;
  int unsigned len_cfg;
  int unsigned line_len;
  int unsigned pick;

  boundary_reduced_difference_stencil_top u_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .sample_i     (sample),
    .line_end_i   (line_end),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .derivative_o (derivative),
    .cell_index_o (cell_index),
    .last_cell_o  (last_cell),
    .saturated_o  (saturated)
  );

  // The checker watches all three channels, keeps its own copy of the
  // registers and the sample window, and compares every output transaction.
  stencil_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .sample_i     (sample),
    .line_end_i   (line_end),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .derivative_i (derivative),
    .cell_index_i (cell_index),
    .last_cell_i  (last_cell),
    .saturated_i  (saturated),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked),
    .clipped_o    (clipped)
  );

  always #CLK_HALF clk = ~clk;

  // Every input starts at a known value, with reset held low.
  initial begin
    clk       = 1'b0;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    sample    = '0;
    line_end  = 1'b0;
    out_ready = 1'b0;
    tx_gaps   = 1'b1;
    rx_gaps   = 1'b1;
    hold_left = 0;
  end

  // Receiver: each cycle it is either ready or not at random. When a long
  // hold-off is requested it counts the cycles itself, keeping ready low.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= !(rx_gaps && $urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  // Watchdog: a run that has not finished by now has hung somewhere.
  initial begin
    #(WATCHDOG_NS);
    $display("tb_boundary_reduced_difference_stencil_top failed");
    $finish;
  end

  function automatic int unsigned effective_length(input int unsigned raw);
    if (raw < LEN_MIN) return LEN_MIN;
    if (raw > LEN_MAX) return LEN_MAX;
    return raw;
  endfunction

  // Mostly full-range values, with the extremes and small values mixed in so
  // that both saturation and exact rounding are exercised.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 8) return SAMPLE_MAX;
    if (sel < 16) return SAMPLE_MIN;
    if (sel < 40) return SAMPLE_W'(int'($urandom_range(512)) - 256);
    return SAMPLE_W'($urandom());
  endfunction

  // One configuration transaction. Valid is lowered and the task then waits on the clock
  // before it returns, so that back-to-back writes never assign valid twice in a step.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= LEN_W'(data);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one sample and returns at the edge at which it was accepted. Valid
  // stays high on return; the idle loop of the next call or a drain lowers it.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
    while (tx_gaps && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    line_end <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
    if (last) lines_sent++;
  endtask

  // Stops offering samples and waits until every predicted result has been
  // taken. The loop always waits on the clock before it tests pending, so valid
  // is never lowered and raised again within one step.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Waits out the front end as well, so the registers may be rewritten.
  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Sends random samples with line_end on sample last_k; for a well-formed
  // line last_k is the last trailing halo sample. At pause_k the sender waits
  // until all results so far have arrived.
  task automatic send_line(input int unsigned last_k, input int pause_k);
    for (int k = 0; k <= int'(last_k); k++) begin
      if (k == pause_k) drain_results();
      push_sample(random_sample(), k == int'(last_k));
    end
  endtask

  task automatic send_full_line(input int unsigned cells, input int pause_k);
    send_line(cells + 2 * HALO - 1, pause_k);
  endtask

  initial begin
    samples_sent = 0;
    lines_sent   = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A write to the unmapped index must change nothing, and
    // a length of zero must act as the minimum of three cells. The first line
    // alternates the sample extremes in uniform sixth order, so the widest
    // differences pass through the halo reads.
    write_register(CFG_UNMAPPED, 13'h1FFF);
    write_register(CFG_LINE_LENGTH, 0);
    for (int k = 0; k < 3 + 2 * HALO; k++) begin
      push_sample((k % 2) ? SAMPLE_MIN : SAMPLE_MAX, k == 3 + 2 * HALO - 1);
    end
    // A line cut short before its first cell: it simply restarts.
    for (int k = 0; k < 4; k++) push_sample(SAMPLE_W'(-1), k == 3);
    settle();

    // Reduced edges at eighth order over nine cells: the one-sided edge
    // stencils, then second, fourth and sixth order, and eighth order in the
    // centre.
    write_register(CFG_LINE_LENGTH, 9);
    write_register(CFG_HIGH_ORDER, 1);
    write_register(CFG_BOUNDARY, 1);
    for (int k = 0; k < 9 + 2 * HALO; k++) begin
      case (k % 4)
        0: push_sample(SAMPLE_MAX, 1'b0);
        1: push_sample(SAMPLE_MIN, 1'b0);
        2: push_sample('0, 1'b0);
        default: push_sample(SAMPLE_W'(-1), k == 9 + 2 * HALO - 1);
      endcase
    end
    settle();

    // Back-pressure: the receiver holds off for a long stretch while a
    // hundred-cell line keeps coming, so the queue fills and the input stalls.
    write_register(CFG_LINE_LENGTH, 100);
    write_register(CFG_HIGH_ORDER, 0);
    hold_left = LONG_HOLD;
    send_full_line(100, -1);
    // Then a line during which the sender pauses half-way until every
    // outstanding result has been taken.
    send_full_line(100, 54);
    settle();

    // A line whose line end comes late: the position runs on past the three
    // cells and no further results follow until the line end finally arrives.
    write_register(CFG_LINE_LENGTH, 1);
    send_line(60, -1);
    send_full_line(3, -1);
    settle();

    // A long line with neither side idling: a length above the maximum acts
    // as the maximum, also as the multiplier, which drives many results into
    // saturation. The line is cut off early by its line end.
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    write_register(CFG_LINE_LENGTH, 13'h1FFF);
    write_register(CFG_HIGH_ORDER, 1);
    write_register(CFG_BOUNDARY, 0);
    send_line(199, -1);
    settle();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;

    // The exact maximum length, cut off early by a line end.
    write_register(CFG_LINE_LENGTH, MAX_CELLS);
    write_register(CFG_BOUNDARY, 1);
    send_line(299, -1);
    settle();

    // Random part: each phase picks fresh register values, mostly short
    // lines, sometimes clamped ones and sometimes lines long enough to clip.
    random_base = samples_sent;
    while (samples_sent - random_base < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 10) len_cfg = $urandom_range(2);
      else if (pick < 80) len_cfg = $urandom_range(3, 16);
      else len_cfg = $urandom_range(100, 300);
      line_len = effective_length(len_cfg);
      write_register(CFG_LINE_LENGTH, len_cfg);
      write_register(CFG_HIGH_ORDER, $urandom_range(13'h1FFF));
      write_register(CFG_BOUNDARY, $urandom_range(13'h1FFF));
      if ($urandom_range(99) < 10) write_register(CFG_UNMAPPED, $urandom_range(13'h1FFF));
      repeat ($urandom_range(1, 4)) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          send_full_line(line_len, -1);
        end else if (pick < 93) begin
          // Early line end somewhere inside the line.
          send_line($urandom_range(line_len + 2 * HALO - 2), -1);
        end else begin
          // Noise with stray line ends, then a line end to realign.
          repeat ($urandom_range(1, 12)) push_sample(random_sample(), $urandom_range(9) == 0);
          push_sample(random_sample(), 1'b1);
        end
      end
      settle();
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d samples in %0d lines; %0d derivatives compared, %0d of them clipped.",
             samples_sent, lines_sent, checked, clipped);
    $display("Lengths from clamped minimum to maximum, both orders, uniform and reduced edges.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_boundary_reduced_difference_stencil_top passed");
    end else begin
      $display("tb_boundary_reduced_difference_stencil_top failed");
    end
    $finish;
  end

endmodule
